[rtl/core/assert_macros.svh]
// shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every edge out of reset
`define CHK_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");

// property checked on every edge, reset included
`define CHK_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) else $error("check failed");

`endif

[rtl/core/sfas_pkg.sv]
package sfas_pkg;

    localparam int SIGN_POS = 31;
    localparam int EXP_LSB  = 23;
    localparam int EXP_W    = 8;
    localparam int FRAC_W   = 23;

    localparam logic CMD_ADD = 1'b0;
    localparam logic CMD_SUB = 1'b1;

    // first stage to second: operands after negate, early-out check and alignment
    typedef struct packed {
        logic        bypass;
        logic [31:0] bypass_val;
        logic        sign;
        logic [7:0]  exp;
        logic [31:0] xv;
        logic [31:0] yv;
    } t_align;

    // second stage to third: magnitude of the sum
    typedef struct packed {
        logic        bypass;
        logic [31:0] bypass_val;
        logic        sign;
        logic [7:0]  exp;
        logic [31:0] mag;
    } t_sum;

    // leading-one position of a 32-bit word, -1 coded as 6'h3f
    function automatic logic [5:0] top_one(input logic [31:0] v);
        logic [5:0] pos;
        pos = 6'h3f;
        for (int i = 0; i < 32; i++) begin
            if (v[i]) begin
                pos = 6'(i);
            end
        end
        return pos;
    endfunction

endpackage

[rtl/core/simple_float32_add_sub_top.sv]
// channel   | ports                                  | direction
// command   | i_start, o_busy, i_cmd, i_operand_a/b  | in
// result    | o_valid, o_result_bits                 | out
//
// four register stages: prepare/align, sum, normalize, output register
// an item enters every cycle; its result passes r_s1, r_s2, r_res3 and r_res4 in
// that order and is then on the ports
// o_busy stays low, the receiver cannot stall, so nothing ever backs up
// synchronous active-low reset clears the valid bits only
module simple_float32_add_sub_top
    import sfas_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic        i_cmd,
    input  logic [31:0] i_operand_a,
    input  logic [31:0] i_operand_b,
    output logic        o_valid,
    output logic [31:0] o_result_bits
);

    logic        r_v1, r_v2, r_v3, r_v4;
    t_align      r_s1, n_s1;
    t_sum        r_s2, n_s2;
    logic [31:0] r_res3, n_res3;
    logic [31:0] r_res4;

    assign o_busy = 1'b0;

    // stage 1: negate, zero tests, sign, align
    always_comb begin
        logic [31:0] x, y, xv, yv;
        logic [7:0]  xe, ye, d;
        logic        xs, ys;
        x = i_operand_a;
        y = i_operand_b;
        if (i_cmd == CMD_SUB) begin
            y = y[SIGN_POS] ? {1'b0, y[30:0]} : ((y == 32'd0) ? 32'd0 : {1'b1, y[30:0]});
        end
        xs = x[SIGN_POS];
        ys = y[SIGN_POS];
        xe = x[30:23];
        ye = y[30:23];
        xv = {8'd0, 1'b1, x[22:0]};
        yv = {8'd0, 1'b1, y[22:0]};
        n_s1.bypass     = 1'b0;
        n_s1.bypass_val = 32'd0;
        if (i_cmd == CMD_SUB && i_operand_a == i_operand_b) begin
            n_s1.bypass = 1'b1;
        end else if (x == 32'd0) begin
            n_s1.bypass = 1'b1;
            n_s1.bypass_val = y;
        end else if (y == 32'd0) begin
            n_s1.bypass = 1'b1;
            n_s1.bypass_val = x;
        end
        if (xe < ye) begin
            d = ye - xe;
            xv = (d >= 8'd32) ? 32'd0 : (xv >> d[4:0]);
            n_s1.exp = ye;
        end else begin
            d = xe - ye;
            yv = (d >= 8'd32) ? 32'd0 : (yv >> d[4:0]);
            n_s1.exp = xe;
        end
        // magnitude of a negative addend against the other's bits, compared unsigned
        n_s1.sign = (xs && (ys || ({1'b0, x[30:0]} > y))) ||
                    (ys && (xs || ({1'b0, y[30:0]} > x)));
        n_s1.xv = xs ? (~xv + 32'd1) : xv;
        n_s1.yv = ys ? (~yv + 32'd1) : yv;
    end

    // stage 2: two's complement sum and magnitude
    always_comb begin
        logic [31:0] s;
        s = r_s1.xv + r_s1.yv;
        n_s2.bypass     = r_s1.bypass;
        n_s2.bypass_val = r_s1.bypass_val;
        n_s2.sign       = r_s1.sign;
        n_s2.exp        = r_s1.exp;
        n_s2.mag        = s[31] ? (~s + 32'd1) : s;
    end

    // stage 3: normalize leading one to bit 23, pick bypass or zero result
    always_comb begin
        logic [5:0]  lead;
        logic [31:0] m;
        logic [7:0]  e;
        lead = top_one(r_s2.mag);
        m = r_s2.mag;
        e = r_s2.exp;
        if (lead != 6'h3f && lead > 6'(EXP_LSB)) begin
            m = m >> (lead - 6'(EXP_LSB));
            e = e + 8'(lead - 6'(EXP_LSB));
        end else if (lead != 6'h3f && lead < 6'(EXP_LSB)) begin
            m = m << (6'(EXP_LSB) - lead);
            e = e - 8'(6'(EXP_LSB) - lead);
        end
        if (r_s2.bypass) begin
            n_res3 = r_s2.bypass_val;
        end else if (r_s2.mag == 32'd0) begin
            n_res3 = 32'd0;
        end else begin
            n_res3 = {r_s2.sign, e, m[22:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1   <= n_s1;
        r_s2   <= n_s2;
        r_res3 <= n_res3;
        r_res4 <= r_res3;
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= i_start && !o_busy;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    assign o_valid       = r_v4;
    assign o_result_bits = r_res4;

endmodule

[rtl/core/sfas_checker.sv]
`include "assert_macros.svh"

module sfas_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        o_busy,
    input  logic        i_cmd,
    input  logic [31:0] i_operand_a,
    input  logic [31:0] i_operand_b,
    input  logic        o_valid,
    input  logic [31:0] o_result_bits
);

    // every accepted beat comes back as a result
    `CHK_IMPL(a_latency, i_clk, i_rst_n, i_start && !o_busy, ##4 o_valid)
    // no result without an accepted beat before it
    `CHK_IMPL(a_no_spurious, i_clk, i_rst_n, o_valid && $past(i_rst_n, 4), $past(i_start && !o_busy, 4))
    // subtracting a value from itself gives plus zero
    `CHK_IMPL(a_self_sub, i_clk, i_rst_n, i_start && !o_busy && i_cmd && i_operand_a == i_operand_b, ##4 (o_result_bits == 32'd0))
    `CHK_ALWAYS(a_never_busy, i_clk, !o_busy)

endmodule

bind simple_float32_add_sub_top sfas_checker u_sfas_checker (.*);
